// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the region table allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTFFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RTFFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define RTFFA_ASSERT(lbl, prop, msg)
`define RTFFA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rtffa_pkg.sv =====
// Types and constants of the region table first-fit allocator.
package rtffa_pkg;

  localparam logic        USER_SPACE_RESET   = 1'b1;
  localparam logic [31:0] REGION_BASE_RESET  = 32'h4000_0000;
  localparam logic [31:0] REGION_LIMIT_RESET = 32'hBFFF_F000;

  localparam logic KIND_MAP   = 1'b0;
  localparam logic KIND_UNMAP = 1'b1;

  typedef enum logic [1:0] {
    CFG_USER_SPACE   = 2'd0,
    CFG_REGION_BASE  = 2'd1,
    CFG_REGION_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] length;
    logic [2:0]  prot;
  } entry_t;

  typedef struct packed {
    logic        hit;
    logic        match;
    logic [31:0] entry_end;
  } range_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_END,
    S_FIXBND,
    S_RD,
    S_EVAL,
    S_ROUND,
    S_FREEBND,
    S_WRITE,
    S_SH_RD,
    S_SH_WR,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/rtffa_if.sv =====
// Request and response channel interfaces of the allocator.
interface rtffa_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] address;
  logic [31:0] length;
  logic        anonymous;
  logic        fixed_place;
  logic [2:0]  protection;

  modport source (output valid, kind, address, length, anonymous, fixed_place, protection,
                  input ready);
  modport sink   (input valid, kind, address, length, anonymous, fixed_place, protection,
                  output ready);
endinterface

interface rtffa_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] placed_address;
  logic [4:0]  entries_used;

  modport source (output valid, ok, placed_address, entries_used, input ready);
  modport sink   (input valid, ok, placed_address, entries_used, output ready);
endinterface

// ===== rtl/core/rtffa_entry_ram.sv =====
// Region table storage: one write port and one registered read port.
module rtffa_entry_ram
  import rtffa_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/rtffa_range_unit.sv =====
// Shared compare unit: tests one table entry against the candidate range.
module rtffa_range_unit
  import rtffa_pkg::*;
(
  input  entry_t      entry,
  input  logic [31:0] cand_addr,
  input  logic [31:0] cand_end,
  input  logic [31:0] cand_len,
  output range_res_t  res
);

  logic [31:0] entry_end;

  // Both ends are taken modulo 2^32, so a range that wraps compares by its wrapped end.
  assign entry_end     = entry.base + entry.length;
  assign res.entry_end = entry_end;
  assign res.hit       = (cand_addr < entry_end) && (cand_end > entry.base);
  assign res.match     = (entry.base == cand_addr) && (entry.length == cand_len);

endmodule

// ===== rtl/core/region_table_first_fit_allocator_core.sv =====
// Top level: sequencer, configuration registers and result register of the allocator.
//
//   channel   direction  handshake            payload
//   in_chan   in         valid/ready          kind, address, length, anonymous,
//                                             fixed_place, protection
//   out_chan  out        valid/ready          ok, placed_address, entries_used
//   cfg_*     in         APB write/read       user_space_present, region_base,
//                                             region_limit
//
// One request is worked at a time; in_chan is ready only while the sequencer idles.
// Each table entry is read through the single read port and then tested in the shared
// compare unit. A free map searches the table in passes, at most MAX_PASSES of them.
// After reset the table is empty and the configuration registers hold their defaults.
// A held result waits in the output register; the next request is still accepted.
`include "assert_macros.svh"

module region_table_first_fit_allocator_core
  import rtffa_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int PAGE_BYTES  = 4096,
  parameter int MAX_PASSES  = 1000
) (
  input  logic        clk,
  input  logic        rst_n,
  rtffa_req_if.sink   in_chan,
  rtffa_rsp_if.source out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PASS_W = $clog2(MAX_PASSES + 1);
  localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

  // Configuration registers.
  logic        usp_r;
  logic [31:0] base_r;
  logic [31:0] limit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usp_r   <= USER_SPACE_RESET;
      base_r  <= REGION_BASE_RESET;
      limit_r <= REGION_LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        CFG_USER_SPACE:   usp_r   <= cfg_pwdata[0];
        CFG_REGION_BASE:  base_r  <= cfg_pwdata;
        CFG_REGION_LIMIT: limit_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      CFG_USER_SPACE:   cfg_prdata = {31'd0, usp_r};
      CFG_REGION_BASE:  cfg_prdata = base_r;
      CFG_REGION_LIMIT: cfg_prdata = limit_r;
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // Sequencer state.
  state_t            state_r, state_nxt;
  logic              kind_r, anon_r, fixed_r;
  logic [31:0]       addr_r, raw_r;
  logic [2:0]        prot_r;
  logic [31:0]       len_r, len_nxt;
  logic [31:0]       a_r, a_nxt;
  logic [31:0]       a_end_r, a_end_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PASS_W-1:0] pass_r, pass_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic [31:0]       res_placed_r, res_placed_nxt;
  logic              out_valid_r;
  logic              out_ok_r;
  logic [31:0]       out_placed_r;
  logic [4:0]        out_used_r;

  logic              in_fire;
  logic              out_load;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_inc2;

  // Table storage and compare unit.
  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  entry_t            ram_wr_data;
  logic              ram_rd_en;
  logic [IDX_W-1:0]  ram_rd_addr;
  entry_t            ram_rd_data;
  range_res_t        cmp_res;

  rtffa_entry_ram #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  rtffa_range_unit u_cmp (
    .entry     (ram_rd_data),
    .cand_addr (a_r),
    .cand_end  (a_end_r),
    .cand_len  (len_r),
    .res       (cmp_res)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign idx_inc       = idx_r + CNT_W'(1);
  assign idx_inc2      = idx_r + CNT_W'(2);
  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_chan.kind;
      addr_r  <= in_chan.address;
      raw_r   <= in_chan.length;
      anon_r  <= in_chan.anonymous;
      fixed_r <= in_chan.fixed_place;
      prot_r  <= in_chan.protection;
    end
    len_r        <= len_nxt;
    a_r          <= a_nxt;
    a_end_r      <= a_end_nxt;
    res_ok_r     <= res_ok_nxt;
    res_placed_r <= res_placed_nxt;
    idx_r        <= idx_nxt;
    pass_r       <= pass_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    a_nxt          = a_r;
    a_end_nxt      = a_end_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    pass_nxt       = pass_r;
    res_ok_nxt     = res_ok_r;
    res_placed_nxt = res_placed_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r[IDX_W-1:0];
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        len_nxt        = (raw_r + PAGE_MASK) & ~PAGE_MASK;
        res_ok_nxt     = 1'b0;
        res_placed_nxt = 32'd0;
        idx_nxt        = '0;
        pass_nxt       = '0;
        state_nxt      = S_CHECK;
      end

      S_CHECK: begin
        if (kind_r == KIND_UNMAP) begin
          a_nxt = addr_r;
          if (!usp_r || ((addr_r & PAGE_MASK) != 32'd0) || (raw_r == 32'd0) ||
              (count_r == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end else if (!usp_r || !anon_r || (raw_r == 32'd0) ||
                     (count_r >= CNT_W'(MAX_ENTRIES))) begin
          state_nxt = S_DONE;
        end else if (fixed_r) begin
          a_nxt = addr_r;
          state_nxt = ((addr_r & PAGE_MASK) != 32'd0) ? S_DONE : S_END;
        end else begin
          a_nxt     = base_r;
          state_nxt = S_END;
        end
      end

      S_END: begin
        a_end_nxt = a_r + len_r;
        idx_nxt   = '0;
        if (fixed_r) begin
          state_nxt = S_FIXBND;
        end else if (count_r == '0) begin
          state_nxt = S_FREEBND;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_FIXBND: begin
        if ((a_r < base_r) || (a_end_r > limit_r) || (a_end_r < a_r)) begin
          state_nxt = S_DONE;
        end else if (count_r == '0) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        idx_nxt = idx_inc;
        if (kind_r == KIND_UNMAP) begin
          if (cmp_res.match) begin
            idx_nxt = idx_r;
            if (idx_inc == count_r) begin
              count_nxt  = count_r - CNT_W'(1);
              res_ok_nxt = 1'b1;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_SH_RD;
            end
          end else begin
            state_nxt = (idx_inc == count_r) ? S_DONE : S_RD;
          end
        end else if (fixed_r) begin
          if (cmp_res.hit) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = (idx_inc == count_r) ? S_WRITE : S_RD;
          end
        end else if (cmp_res.hit) begin
          // First overlap: restart the search past this region on a new pass.
          if (pass_r == PASS_W'(MAX_PASSES - 1)) begin
            state_nxt = S_DONE;
          end else begin
            pass_nxt  = pass_r + PASS_W'(1);
            a_nxt     = cmp_res.entry_end;
            state_nxt = S_ROUND;
          end
        end else begin
          state_nxt = (idx_inc == count_r) ? S_FREEBND : S_RD;
        end
      end

      S_ROUND: begin
        a_nxt     = (a_r + PAGE_MASK) & ~PAGE_MASK;
        state_nxt = S_END;
      end

      S_FREEBND: begin
        state_nxt = ((a_end_r > limit_r) || (a_end_r < a_r)) ? S_DONE : S_WRITE;
      end

      S_WRITE: begin
        ram_wr_en      = 1'b1;
        ram_wr_addr    = count_r[IDX_W-1:0];
        ram_wr_data    = '{base: a_r, length: len_r, prot: prot_r};
        count_nxt      = count_r + CNT_W'(1);
        res_ok_nxt     = 1'b1;
        res_placed_nxt = a_r;
        state_nxt      = S_DONE;
      end

      // Removal moves each later entry down one place, read in S_SH_RD and written in S_SH_WR.
      S_SH_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx_inc[IDX_W-1:0];
        state_nxt   = S_SH_WR;
      end

      S_SH_WR: begin
        ram_wr_en = 1'b1;
        idx_nxt   = idx_inc;
        if (idx_inc2 == count_r) begin
          count_nxt  = count_r - CNT_W'(1);
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SH_RD;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r     <= res_ok_r;
      out_placed_r <= res_placed_r;
      out_used_r   <= 5'(count_r);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.ok             = out_ok_r;
  assign out_chan.placed_address = out_placed_r;
  assign out_chan.entries_used   = out_used_r;

  `RTFFA_ASSERT(a_count_bound, (count_r <= CNT_W'(MAX_ENTRIES)), "entry count above table depth")
  `RTFFA_ASSERT_IMPL(a_write_room, (state_r == S_WRITE), (count_r < CNT_W'(MAX_ENTRIES)), "table write with no free entry")
  `RTFFA_ASSERT(a_count_step, (count_r != $past(count_r)) |-> ((count_r == $past(count_r) + CNT_W'(1)) || (count_r == $past(count_r) - CNT_W'(1))), "entry count moved by more than one")
  `RTFFA_ASSERT_IMPL(a_fail_zero, (out_chan.valid && !out_chan.ok), (out_chan.placed_address == 32'd0), "rejected transaction reports an address")
  `RTFFA_ASSERT(a_busy_after_accept, in_fire |=> (state_r != S_IDLE), "sequencer idle after accepting a transaction")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the region table first-fit allocator core.
module tb_top;
  import rtffa_pkg::*;

  localparam int          TABLE_DEPTH    = 16;
  localparam int          PAGE           = 4096;
  localparam int          PASS_LIMIT     = 1000;
  localparam logic [31:0] PAGE_MASK      = 32'(PAGE - 1);
  // The limit leaves room for a number of searches that run through every pass.
  localparam int          LIMIT_CYCLES   = 6_000_000;
  localparam int          DRAIN_CYCLES   = 700;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          NUM_SETTINGS   = 7;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] length;
    logic        anonymous;
    logic        fixed_place;
    logic [2:0]  protection;
  } request_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] placed_address;
    logic [4:0]  entries_used;
  } outcome_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rtffa_req_if req_ch ();
  rtffa_rsp_if rsp_ch ();

  region_table_first_fit_allocator_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (req_ch),
    .out_chan    (rsp_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mirror of the region table and of the configuration registers.
  logic [31:0] map_base [TABLE_DEPTH];
  logic [31:0] map_len  [TABLE_DEPTH];
  logic [2:0]  map_prot [TABLE_DEPTH];
  int          map_count;
  logic        space_on;
  logic [31:0] win_base;
  logic [31:0] win_limit;

  request_t pending_requests [$];
  outcome_t expected_outcomes [$];

  int errors;
  int cycles;
  int n_requests;
  int n_placed;
  int n_released;
  int n_rejected;
  int n_full;
  int n_settings;

  bit req_busy;
  bit req_taken;
  int burst_left;
  int gap_left;
  bit holdoff_req;
  int hold_left;
  int rx_mode;
  int rx_span;

  function automatic logic [31:0] page_up(input logic [31:0] v);
    return (v + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  function automatic bit collides(input int i, input logic [31:0] a, input logic [31:0] len);
    logic [31:0] stop;
    logic [31:0] reach;
    stop  = map_base[i] + map_len[i];
    reach = a + len;
    return (a < stop) && (reach > map_base[i]);
  endfunction

  function automatic bit try_map(input request_t r, output logic [31:0] where);
    logic [31:0] a;
    logic [31:0] len;
    logic [31:0] reach;
    bit          clear;
    where = '0;
    if (!space_on || !r.anonymous || r.length == 0) return 1'b0;
    len = page_up(r.length);
    if (map_count >= TABLE_DEPTH) return 1'b0;
    if (r.fixed_place) begin
      a     = r.address;
      reach = a + len;
      if ((a & PAGE_MASK) != 0) return 1'b0;
      if (a < win_base || reach > win_limit || reach < a) return 1'b0;
      for (int i = 0; i < map_count; i++)
        if (collides(i, a, len)) return 1'b0;
    end else begin
      a     = win_base;
      clear = 1'b0;
      // Each pass restarts behind the first region that the candidate runs into.
      for (int pass = 0; pass < PASS_LIMIT && !clear; pass++) begin
        clear = 1'b1;
        for (int i = 0; i < map_count; i++) begin
          if (collides(i, a, len)) begin
            a     = page_up(map_base[i] + map_len[i]);
            clear = 1'b0;
            break;
          end
        end
      end
      reach = a + len;
      if (!clear || reach > win_limit || reach < a) return 1'b0;
    end
    map_base[map_count] = a;
    map_len[map_count]  = len;
    map_prot[map_count] = r.protection;
    map_count++;
    where = a;
    return 1'b1;
  endfunction

  function automatic bit try_unmap(input request_t r);
    logic [31:0] len;
    int          hit;
    if (!space_on || (r.address & PAGE_MASK) != 0 || r.length == 0) return 1'b0;
    len = page_up(r.length);
    hit = -1;
    for (int i = 0; i < map_count; i++) begin
      if (map_base[i] == r.address && map_len[i] == len) begin
        hit = i;
        break;
      end
    end
    if (hit < 0) return 1'b0;
    for (int i = hit; i + 1 < map_count; i++) begin
      map_base[i] = map_base[i + 1];
      map_len[i]  = map_len[i + 1];
      map_prot[i] = map_prot[i + 1];
    end
    map_count--;
    return 1'b1;
  endfunction

  function automatic outcome_t predict_outcome(input request_t r);
    outcome_t    o;
    logic [31:0] where;
    bit          ok;
    where = '0;
    if (r.kind == KIND_UNMAP) ok = try_unmap(r);
    else ok = try_map(r, where);
    o.ok             = ok;
    o.placed_address = ok ? where : 32'h0;
    o.entries_used   = map_count[4:0];
    return o;
  endfunction

  function automatic logic [31:0] rand_length();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return $urandom_range(1, 4 * PAGE);
    if (sel < 18) return $urandom_range(1, 64 * PAGE);
    if (sel == 18) return $urandom;
    return $urandom_range(32'hFFFF_F001, 32'hFFFF_FFFF);
  endfunction

  // Any raw length that rounds up to the given page-rounded length.
  function automatic logic [31:0] raw_length_for(input logic [31:0] len);
    if (len == 0) return $urandom_range(32'hFFFF_F001, 32'hFFFF_FFFF);
    return len - $urandom_range(0, PAGE - 1);
  endfunction

  // Driver: offers queued requests in bursts separated by random gaps.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    bit       offer;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_taken) begin
        req_busy  = 1'b0;
        req_taken = 1'b0;
      end
      if (!req_busy) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          nxt                    = pending_requests.pop_front();
          offer                  = 1'b1;
          req_busy               = 1'b1;
          req_ch.kind           <= nxt.kind;
          req_ch.address        <= nxt.address;
          req_ch.length         <= nxt.length;
          req_ch.anonymous      <= nxt.anonymous;
          req_ch.fixed_place    <= nxt.fixed_place;
          req_ch.protection     <= nxt.protection;
          burst_left--;
          if (burst_left <= 0) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(20, 60);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 10);
              gap_left   = $urandom_range(1, 20);
            end
          end
        end
        req_ch.valid <= offer;
      end
    end
  end

  // Receiver: stalls in modes of random length, plus an occasional long hold-off.
  always @(negedge clk) begin : drive_ready
    bit rdy;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      hold_left   = HOLDOFF_CYCLES - 1;
      rdy         = 1'b0;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(20, 200);
      end
      rx_span--;
      case (rx_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 5) == 0);
      endcase
    end
    rsp_ch.ready <= rdy;
  end

  // Monitor: checks each result transaction and predicts each request transaction.
  always @(posedge clk) begin : watch_channels
    outcome_t want;
    request_t got;
    if (rst_n) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with nothing pending: ok=%0b placed_address=%h entries_used=%0d",
                 rsp_ch.ok, rsp_ch.placed_address, rsp_ch.entries_used);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_ch.ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, rsp_ch.ok);
            errors++;
          end
          if (rsp_ch.placed_address !== want.placed_address) begin
            $error("placed_address: expected %h, actual %h",
                   want.placed_address, rsp_ch.placed_address);
            errors++;
          end
          if (rsp_ch.entries_used !== want.entries_used) begin
            $error("entries_used: expected %0d, actual %0d",
                   want.entries_used, rsp_ch.entries_used);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        got.kind        = req_ch.kind;
        got.address     = req_ch.address;
        got.length      = req_ch.length;
        got.anonymous   = req_ch.anonymous;
        got.fixed_place = req_ch.fixed_place;
        got.protection  = req_ch.protection;
        if (got.kind == KIND_MAP && map_count == TABLE_DEPTH) n_full++;
        want = predict_outcome(got);
        expected_outcomes.push_back(want);
        n_requests++;
        if (!want.ok) n_rejected++;
        else if (got.kind == KIND_MAP) n_placed++;
        else n_released++;
        req_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_request(input logic kind, input logic [31:0] address,
                               input logic [31:0] length, input logic anonymous,
                               input logic fixed_place, input logic [2:0] protection);
    request_t r;
    r.kind        = kind;
    r.address     = address;
    r.length      = length;
    r.anonymous   = anonymous;
    r.fixed_place = fixed_place;
    r.protection  = protection;
    pending_requests.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || req_busy || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
    logic [31:0] mask;
    logic [31:0] seen;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {r, 2'b00};
    cfg_pwdata  = v;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    seen = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    mask = (r == CFG_USER_SPACE) ? 32'h1 : 32'hFFFF_FFFF;
    if ((seen & mask) !== (v & mask)) begin
      $error("%s read back: expected %h, actual %h", r.name(), v & mask, seen & mask);
      errors++;
    end
    case (r)
      CFG_USER_SPACE:   space_on  = v[0];
      CFG_REGION_BASE:  win_base  = v;
      CFG_REGION_LIMIT: win_limit = v;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic on, input logic [31:0] lo, input logic [31:0] hi);
    wait_idle();
    write_reg(CFG_USER_SPACE, {31'b0, on});
    write_reg(CFG_REGION_BASE, lo);
    write_reg(CFG_REGION_LIMIT, hi);
    n_settings++;
  endtask

  // Mostly well-formed requests aimed at the live table, with some broken ones and noise.
  task automatic make_request(output request_t r);
    int unsigned pick;
    int unsigned unmap_share;
    int          slot;
    r.kind        = KIND_MAP;
    r.address     = $urandom;
    r.length      = rand_length();
    r.anonymous   = 1'b1;
    r.fixed_place = 1'b0;
    r.protection  = 3'($urandom_range(0, 7));
    unmap_share   = (map_count >= 12) ? 45 : 25;
    pick          = $urandom_range(0, 99);
    if (pick < 10) begin
      r.kind        = 1'($urandom_range(0, 1));
      r.length      = ($urandom_range(0, 7) == 0) ? 32'h0 : 32'($urandom);
      r.anonymous   = 1'($urandom_range(0, 1));
      r.fixed_place = 1'($urandom_range(0, 1));
    end else if (pick < 10 + unmap_share) begin
      r.kind        = KIND_UNMAP;
      r.anonymous   = 1'($urandom_range(0, 1));
      r.fixed_place = 1'($urandom_range(0, 1));
      if (map_count > 0) begin
        slot      = $urandom_range(0, map_count - 1);
        r.address = map_base[slot];
        r.length  = raw_length_for(map_len[slot]);
      end else begin
        r.address = $urandom & ~PAGE_MASK;
      end
      case ($urandom_range(0, 15))
        0: r.length  = r.length + PAGE;
        1: r.address = r.address | 32'($urandom_range(1, PAGE - 1));
        default: ;
      endcase
    end else begin
      if (pick < 30 + unmap_share) begin
        r.fixed_place = 1'b1;
        if (win_limit > win_base)
          r.address = (win_base + $urandom_range(0, win_limit - win_base)) & ~PAGE_MASK;
        else
          r.address = $urandom & ~PAGE_MASK;
      end
      case ($urandom_range(0, 23))
        0: r.anonymous = 1'b0;
        1: r.length    = 32'h0;
        default: ;
      endcase
    end
  endtask

  initial begin : stimulus
    request_t    r;
    logic [31:0] set_on    [NUM_SETTINGS];
    logic [31:0] set_base  [NUM_SETTINGS];
    logic [31:0] set_limit [NUM_SETTINGS];
    int          set_items [NUM_SETTINGS];
    logic [31:0] left_base [$];
    logic [31:0] left_len  [$];

    set_on    = '{1, 1, 1, 0, 1, 1, 1};
    set_base  = '{32'h4000_0000, 32'h0000_0000, 32'h1000_0000, 32'hFFFF_FFFF,
                  32'hFFFF_F000, 32'h0000_1000, 32'h4000_0000};
    set_limit = '{32'hBFFF_F000, 32'hFFFF_FFFF, 32'h1004_0000, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'h0010_0000, 32'hBFFF_F000};
    set_items = '{300, 300, 250, 60, 90, 200, 200};

    rst_n                 = 1'b0;
    cfg_psel              = 1'b0;
    cfg_penable           = 1'b0;
    cfg_pwrite            = 1'b0;
    cfg_paddr             = '0;
    cfg_pwdata            = '0;
    req_ch.valid          = 1'b0;
    req_ch.kind           = KIND_MAP;
    req_ch.address        = '0;
    req_ch.length         = '0;
    req_ch.anonymous      = 1'b0;
    req_ch.fixed_place    = 1'b0;
    req_ch.protection     = '0;
    rsp_ch.ready          = 1'b0;
    space_on              = USER_SPACE_RESET;
    win_base              = REGION_BASE_RESET;
    win_limit             = REGION_LIMIT_RESET;
    map_count             = 0;
    burst_left            = 8;
    gap_left              = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Rejections of the map checks, rounding, limits and exact unmap matching.
    queue_request(KIND_MAP,   32'hFFFF_FFFF, 32'h0000_1000, 1'b0, 1'b0, 3'd7);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 3'd0);
    queue_request(KIND_MAP,   32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 3'd7);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_1000, 1'b1, 1'b0, 3'd0);
    queue_request(KIND_MAP,   32'h4000_0000, 32'h0000_1000, 1'b1, 1'b1, 3'd1);
    queue_request(KIND_MAP,   32'h4000_5001, 32'h0000_1000, 1'b1, 1'b1, 3'd2);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_1000, 1'b1, 1'b1, 3'd3);
    queue_request(KIND_MAP,   32'hBFFF_E000, 32'h0000_2000, 1'b1, 1'b1, 3'd4);
    queue_request(KIND_MAP,   32'hBFFF_E000, 32'h0000_1000, 1'b1, 1'b1, 3'd5);
    queue_request(KIND_MAP,   32'h8000_0000, 32'h9000_0000, 1'b1, 1'b1, 3'd6);
    queue_request(KIND_MAP,   32'h5000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd7);
    queue_request(KIND_MAP,   32'h5000_0000, 32'h0000_1000, 1'b1, 1'b1, 3'd0);
    queue_request(KIND_UNMAP, 32'h5000_0000, 32'hFFFF_F001, 1'b0, 1'b0, 3'd0);
    queue_request(KIND_UNMAP, 32'h4000_0001, 32'h0000_1000, 1'b1, 1'b1, 3'd7);
    queue_request(KIND_UNMAP, 32'h4000_1000, 32'h0000_0000, 1'b0, 1'b1, 3'd0);
    queue_request(KIND_UNMAP, 32'h4000_1000, 32'h0000_2000, 1'b1, 1'b0, 3'd0);
    queue_request(KIND_UNMAP, 32'h4000_0000, 32'h0000_0FFF, 1'b0, 1'b0, 3'd0);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_3000, 1'b1, 1'b0, 3'd2);
    queue_request(KIND_MAP,   32'hFFFF_FFFF, 32'h0000_0800, 1'b1, 1'b0, 3'd5);
    queue_request(KIND_MAP,   32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'd3);
    wait_idle();
    write_reg(CFG_USER_SPACE, 32'h0);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_1000, 1'b1, 1'b0, 3'd1);
    queue_request(KIND_UNMAP, 32'h4000_1000, 32'h0000_1000, 1'b0, 1'b0, 3'd0);
    wait_idle();
    write_reg(CFG_USER_SPACE, 32'h1);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      apply_setting(set_on[s][0], set_base[s], set_limit[s]);
      if (s == 0 || s == 5) holdoff_req = 1'b1;
      for (int n = 0; n < set_items[s]; n++) begin
        while (pending_requests.size() >= 2) @(negedge clk);
        make_request(r);
        pending_requests.push_back(r);
      end
    end

    // Empty the table, then build a table in which the first-fit search wraps past
    // the top of the address space and places a region at address zero.
    wait_idle();
    for (int i = 0; i < map_count; i++) begin
      left_base.push_back(map_base[i]);
      left_len.push_back(map_len[i]);
    end
    foreach (left_base[i])
      queue_request(KIND_UNMAP, left_base[i], raw_length_for(left_len[i]), 1'b0, 1'b0, 3'd0);
    apply_setting(1'b1, 32'hFFFF_E001, 32'hFFFF_FFFF);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_1000, 1'b1, 1'b0, 3'd1);
    queue_request(KIND_MAP,   32'h0000_0000, 32'hFFFF_E000, 1'b1, 1'b0, 3'd2);
    queue_request(KIND_MAP,   32'h0000_0000, 32'h0000_1000, 1'b1, 1'b0, 3'd3);
    queue_request(KIND_UNMAP, 32'h0000_0000, 32'hFFFF_E000, 1'b1, 1'b1, 3'd0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_outcomes.size() != 0) begin
      $error("%0d results never arrived", expected_outcomes.size());
      errors++;
    end
    $display("Ran %0d requests under %0d register settings, with %0d mismatches.",
             n_requests, n_settings + 1, errors);
    $display("Placed %0d regions, released %0d, rejected %0d (%0d against a full table).",
             n_placed, n_released, n_rejected, n_full);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
